[sv/wino_pkg.sv]
package wino_pkg;

    typedef enum logic [1:0] {
        MODE_WEIGHT  = 2'd0,
        MODE_INPUT   = 2'd1,
        MODE_COMPUTE = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [0:0] {
        CFG_IN_COUNT  = 1'b0,
        CFG_OUT_COUNT = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_DRAIN,
        ST_OUT
    } exec_state_t;

    localparam int unsigned ACC_W     = 48;
    localparam int unsigned CH_W      = 6;
    localparam int unsigned CNT_W     = 7;

    // Queue entry passed from the front end to the compute engine
    typedef struct packed {
        logic [CH_W-1:0]  out_channel;
        logic [CNT_W-1:0] n_channels;
    } job_t;

endpackage

[sv/wino_front.sv]
module wino_front #(
    parameter int MAX_IN_CHANNELS  = 64,
    parameter int MAX_OUT_CHANNELS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_mode,
    input  logic [5:0]                      s_out_channel,
    input  logic [5:0]                      s_in_channel,
    input  logic [3:0]                      s_position,
    input  logic signed [15:0]              s_value,
    input  logic [6:0]                      in_count,
    input  logic [6:0]                      out_count,
    input  logic                            busy,
    output logic                            wr_w_en,
    output logic                            wr_x_en,
    output logic [5:0]                      wr_oc,
    output logic [5:0]                      wr_ic,
    output logic [3:0]                      wr_pos,
    output logic signed [15:0]              wr_val,
    output logic                            job_valid,
    input  logic                            job_ready,
    output wino_pkg::job_t                  job
);

    localparam logic [7:0] MaxIn  = 8'(MAX_IN_CHANNELS);
    localparam logic [7:0] MaxOut = 8'(MAX_OUT_CHANNELS);

    logic           q_valid_reg;
    wino_pkg::job_t q_job_reg;
    logic           accept;
    logic           is_cmp;
    logic           cmp_ok;
    logic [6:0]     n_clamp;

    // Writes must not overtake a compute that still reads the stores
    assign s_ready = !q_valid_reg && !busy;
    assign accept  = s_valid && s_ready;

    assign is_cmp  = (s_mode == wino_pkg::MODE_COMPUTE);
    assign cmp_ok  = ({1'b0, s_out_channel} < out_count)
                     && ({2'b00, s_out_channel} < MaxOut);
    assign n_clamp = ({1'b0, in_count} > MaxIn) ? 7'(MaxIn) : in_count;

    assign wr_w_en = accept && (s_mode == wino_pkg::MODE_WEIGHT)
                     && ({2'b00, s_out_channel} < MaxOut)
                     && ({2'b00, s_in_channel} < MaxIn);
    assign wr_x_en = accept && (s_mode == wino_pkg::MODE_INPUT)
                     && ({2'b00, s_in_channel} < MaxIn);
    assign wr_oc   = s_out_channel;
    assign wr_ic   = s_in_channel;
    assign wr_pos  = s_position;
    assign wr_val  = s_value;

    // Hold one classified compute job for the engine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else if (accept && is_cmp && cmp_ok) begin
            q_valid_reg <= 1'b1;
        end else if (job_ready) begin
            q_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            q_job_reg.out_channel <= s_out_channel;
            q_job_reg.n_channels  <= n_clamp;
        end
    end

    assign job_valid = q_valid_reg;
    assign job       = q_job_reg;

endmodule

[sv/wino_engine.sv]
module wino_engine #(
    parameter int MAX_IN_CHANNELS  = 64,
    parameter int MAX_OUT_CHANNELS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_w_en,
    input  logic               wr_x_en,
    input  logic [5:0]         wr_oc,
    input  logic [5:0]         wr_ic,
    input  logic [3:0]         wr_pos,
    input  logic signed [15:0] wr_val,
    input  logic               job_valid,
    output logic               job_ready,
    input  wino_pkg::job_t     job,
    output logic               busy,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_result_channel,
    output logic [1:0]         m_out_index,
    output logic signed [47:0] m_result_value,
    output logic               m_last
);

    localparam int IcW  = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
    localparam int OcW  = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int RowW = IcW + OcW;
    localparam int WRows = 1 << RowW;
    localparam int ACW  = wino_pkg::ACC_W;

    // One row holds the 16 elements of one tile
    logic [16*16-1:0] w_mem [WRows];
    logic [16*16-1:0] x_mem [MAX_IN_CHANNELS];
    logic [15:0]      w_we_mask;

    logic [16*16-1:0] w_row_reg;
    logic [16*16-1:0] x_row_reg;

    wino_pkg::exec_state_t state_reg, state_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [6:0]   n_reg;
    logic [5:0]   oc_reg;
    logic [1:0]   oi_reg, oi_next;
    logic         rd_en;
    logic         mac_en;
    logic         clr;
    logic         y_load;
    logic signed [ACW-1:0] m_reg [16];
    logic signed [ACW-1:0] y_reg [4];
    logic signed [ACW-1:0] t [8];

    logic [RowW-1:0] w_addr_wr;
    logic [RowW-1:0] w_addr_rd;
    logic [IcW-1:0]  rd_ic;

    assign rd_ic     = cnt_reg[IcW-1:0];
    assign w_addr_wr = RowW'({wr_oc, 8'b0} >> (8 - IcW)) | RowW'(wr_ic[IcW-1:0]);
    assign w_addr_rd = RowW'({oc_reg, 8'b0} >> (8 - IcW)) | RowW'(rd_ic);

    // Store writes, each element landing in its slot of the row; row fetch on rd_en
    always_ff @(posedge aclk) begin
        if (wr_w_en) begin
            w_mem[w_addr_wr][wr_pos*16 +: 16] <= wr_val;
        end
        if (wr_x_en) begin
            x_mem[wr_ic[IcW-1:0]][wr_pos*16 +: 16] <= wr_val;
        end
        if (rd_en) begin
            w_row_reg <= w_mem[w_addr_rd];
            x_row_reg <= x_mem[rd_ic];
        end
    end
    assign w_we_mask = 16'hFFFF;

    // Input transform of the fetched tile, then elementwise product
    logic signed [17:0] d  [16];
    logic signed [17:0] tt [16];
    logic signed [17:0] v  [16];
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            d[i] = 18'(signed'(x_row_reg[i*16 +: 16]));
        end
        for (int i = 0; i < 4; i++) begin
            tt[i]      = d[i] - d[8+i];
            tt[4+i]    = d[4+i] + d[8+i];
            tt[8+i]    = d[8+i] - d[4+i];
            tt[12+i]   = d[4+i] - d[12+i];
        end
        for (int i = 0; i < 4; i++) begin
            v[i*4]   = tt[i*4] - tt[i*4+2];
            v[i*4+1] = tt[i*4+1] + tt[i*4+2];
            v[i*4+2] = tt[i*4+2] - tt[i*4+1];
            v[i*4+3] = tt[i*4+1] - tt[i*4+3];
        end
    end

    logic signed [33:0] p_reg [16];
    always_ff @(posedge aclk) begin
        if (mac_en) begin
            for (int i = 0; i < 16; i++) begin
                p_reg[i] <= 34'(signed'(w_row_reg[i*16 +: 16] & w_we_mask)) * 34'(v[i]);
            end
        end
    end

    // Accumulate one channel's products per cycle
    logic acc_en_reg;
    always_ff @(posedge aclk) begin
        if (clr) begin
            for (int i = 0; i < 16; i++) m_reg[i] <= '0;
        end else if (acc_en_reg) begin
            for (int i = 0; i < 16; i++) m_reg[i] <= m_reg[i] + ACW'(p_reg[i]);
        end
    end

    // Output transform
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            t[i]   = m_reg[i] + m_reg[4+i] + m_reg[8+i];
            t[4+i] = m_reg[4+i] - m_reg[8+i] - m_reg[12+i];
        end
    end
    always_ff @(posedge aclk) begin
        if (y_load) begin
            for (int i = 0; i < 2; i++) begin
                y_reg[i*2]   <= t[i*4] + t[i*4+1] + t[i*4+2];
                y_reg[i*2+1] <= t[i*4+1] - t[i*4+2] - t[i*4+3];
            end
        end
    end

    // Sequencer state
    logic rd_pend_reg, mac_pend_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wino_pkg::ST_IDLE;
            cnt_reg      <= '0;
            oi_reg       <= '0;
            rd_pend_reg  <= 1'b0;
            mac_pend_reg <= 1'b0;
            acc_en_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            oi_reg       <= oi_next;
            rd_pend_reg  <= rd_en;
            mac_pend_reg <= rd_pend_reg;
            acc_en_reg   <= rd_pend_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (job_valid && job_ready) begin
            oc_reg <= job.out_channel;
            n_reg  <= job.n_channels;
        end
    end
    assign mac_en = rd_pend_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        oi_next    = oi_reg;
        rd_en      = 1'b0;
        clr        = 1'b0;
        y_load     = 1'b0;
        job_ready  = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            wino_pkg::ST_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    clr        = 1'b1;
                    cnt_next   = '0;
                    state_next = wino_pkg::ST_READ;
                end
            end
            wino_pkg::ST_READ: begin
                if (cnt_reg < n_reg) begin
                    rd_en    = 1'b1;
                    cnt_next = cnt_reg + 7'd1;
                end else begin
                    state_next = wino_pkg::ST_DRAIN;
                end
            end
            wino_pkg::ST_DRAIN: begin
                if (!rd_pend_reg && !mac_pend_reg && !acc_en_reg) begin
                    y_load     = 1'b1;
                    oi_next    = '0;
                    state_next = wino_pkg::ST_OUT;
                end
            end
            wino_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    oi_next = oi_reg + 2'd1;
                    if (oi_reg == 2'd3) begin
                        state_next = wino_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = wino_pkg::ST_IDLE;
        endcase
    end

    assign busy             = (state_reg != wino_pkg::ST_IDLE);
    assign m_result_channel = oc_reg;
    assign m_out_index      = oi_reg;
    assign m_result_value   = y_reg[oi_reg];
    assign m_last           = (oi_reg == 2'd3);

endmodule

[sv/winograd_f23_tile_conv_unit.sv]
// Channel   | Handshake          | Payload
// s_        | s_valid / s_ready  | mode, out_channel, in_channel, position, value
// m_        | m_valid / m_ready  | result_channel, out_index, result_value, last
// cfg       | cfg_we             | cfg_index, cfg_data
//
// Store writes are accepted back to back. A compute request ends in four result
// transfers; the engine reads one channel row from the weight and tile memories per
// cycle for each of the N input channels, N being in_count clamped to MAX_IN_CHANNELS.
// Reset (aresetn, synchronous, low) clears control only; stores are undefined.
// s_ready stays low while a compute is queued or running; m_ready stalls hold
// the current result.
module winograd_f23_tile_conv_unit #(
    parameter int MAX_IN_CHANNELS  = 64,
    parameter int MAX_OUT_CHANNELS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [5:0]         s_out_channel,
    input  logic [5:0]         s_in_channel,
    input  logic [3:0]         s_position,
    input  logic signed [15:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_result_channel,
    output logic [1:0]         m_out_index,
    output logic signed [47:0] m_result_value,
    output logic               m_last
);

    logic [6:0] in_count_reg, out_count_reg;
    logic busy, wr_w_en, wr_x_en, job_valid, job_ready;
    logic [5:0] wr_oc, wr_ic;
    logic [3:0] wr_pos;
    logic signed [15:0] wr_val;
    wino_pkg::job_t job;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_count_reg  <= 7'd64;
            out_count_reg <= 7'd64;
        end else if (cfg_we) begin
            if (cfg_index == wino_pkg::CFG_IN_COUNT) begin
                in_count_reg <= cfg_data;
            end else begin
                out_count_reg <= cfg_data;
            end
        end
    end

    wino_front #(
        .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
        .MAX_OUT_CHANNELS(MAX_OUT_CHANNELS)
    ) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_mode, .s_out_channel,
        .s_in_channel, .s_position, .s_value,
        .in_count(in_count_reg), .out_count(out_count_reg), .busy,
        .wr_w_en, .wr_x_en, .wr_oc, .wr_ic, .wr_pos, .wr_val,
        .job_valid, .job_ready, .job
    );

    wino_engine #(
        .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
        .MAX_OUT_CHANNELS(MAX_OUT_CHANNELS)
    ) u_engine (
        .aclk, .aresetn, .wr_w_en, .wr_x_en, .wr_oc, .wr_ic, .wr_pos, .wr_val,
        .job_valid, .job_ready, .job, .busy,
        .m_valid, .m_ready, .m_result_channel, .m_out_index,
        .m_result_value, .m_last
    );

    // Last flag only on the fourth pixel
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_out_index == 2'd3)))
        else $error("last flag out of place");

    // No new item while results are pending
    a_no_accept_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted during output");

    // Index advances after each transfer within a tile
    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (m_valid
            && m_out_index == $past(m_out_index) + 2'd1))
        else $error("output index skipped");

endmodule
